// ===== rtl/core/fwis_pkg.sv =====
// fwis_pkg: shared constants, types and helpers of the fixed-weight index sampler
// used by fwis_cell, fwis_lemire and fixed_weight_index_sampler; depends on nothing
package fwis_pkg;

    localparam int unsigned MAX_WEIGHT = 128;
    localparam int unsigned COUNT_W    = $clog2(MAX_WEIGHT + 1);
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ACC_W      = 64;
    localparam int unsigned WEIGHT_W   = 8;
    localparam int unsigned LEVEL_W    = 2;
    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned REG_SEL_W  = 2;
    localparam int unsigned LIMB_CNT_W = 4;

    // register map, byte address is 4 * index
    localparam logic [REG_SEL_W-1:0] REG_RANGE_SIZE = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_WEIGHT     = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_SECURITY   = 2'd2;

    localparam logic [LEVEL_W-1:0] SEC_128 = 2'd0;
    localparam logic [LEVEL_W-1:0] SEC_192 = 2'd1;
    localparam logic [LEVEL_W-1:0] SEC_256 = 2'd2;

    localparam logic [LIMB_CNT_W-1:0] LIMBS_128 = 4'd6;
    localparam logic [LIMB_CNT_W-1:0] LIMBS_192 = 4'd8;
    localparam logic [LIMB_CNT_W-1:0] LIMBS_256 = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } fwis_state_t;

    // query travelling down the overlay chain
    typedef struct packed {
        logic [COUNT_W-1:0] remaining;
        logic [COUNT_W-1:0] idx_i;
        logic [WORD_W-1:0]  idx_j;
        logic [WORD_W-1:0]  cur_i;
        logic [WORD_W-1:0]  cur_j;
    } fwis_token_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } fwis_mac_ctrl_t;

    function automatic logic [LIMB_CNT_W-1:0] limbs_per_draw(input logic [LEVEL_W-1:0] level);
        logic [LIMB_CNT_W-1:0] n;
        case (level)
            SEC_128: n = LIMBS_128;
            SEC_192: n = LIMBS_192;
            default: n = LIMBS_256;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/fixed_weight_index_sampler.sv =====
// fixed_weight_index_sampler: top level, control, register port and overlay chain
// depends on fwis_pkg, fwis_lemire and fwis_cell
// each tape beat goes through accept, multiply, accumulate and limb check in turn
// the beat that ends a draw then walks the chain (skipped on a config error) and emits, held while stalled
// a draw thus takes 6 / 8 / 10 beats, taken one beat at a time
// reset clears control and config (range 1, weight 1, level 0); overlay entries are not cleared
module fixed_weight_index_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fwis_pkg::ADDR_W-1:0]       paddr,
    input  logic [fwis_pkg::WORD_W-1:0]       pwdata,
    output logic [fwis_pkg::WORD_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              tape_valid,
    output logic                              tape_stall,
    input  logic [fwis_pkg::WORD_W-1:0]       tape_word,
    output logic                              draw_valid,
    input  logic                              draw_stall,
    output logic [fwis_pkg::WORD_W-1:0]       drawn_index,
    output logic                              set_done,
    output logic                              config_error
);

    localparam int unsigned MW = fwis_pkg::MAX_WEIGHT;

    fwis_pkg::fwis_state_t state_reg;
    fwis_pkg::fwis_state_t state_next;

    logic [fwis_pkg::WORD_W-1:0]     range_size_reg;
    logic [fwis_pkg::WEIGHT_W-1:0]   weight_reg;
    logic [fwis_pkg::LEVEL_W-1:0]    security_reg;
    logic [fwis_pkg::REG_SEL_W-1:0]  reg_sel;
    logic                            cfg_write;

    logic [fwis_pkg::WORD_W-1:0]     limb_reg;
    logic [fwis_pkg::LIMB_CNT_W-1:0] limb_count_reg;
    logic [fwis_pkg::LIMB_CNT_W-1:0] limb_count_next;
    logic [fwis_pkg::COUNT_W-1:0]    draw_count_reg;
    logic [fwis_pkg::COUNT_W-1:0]    draw_count_next;

    logic [fwis_pkg::WORD_W-1:0]     res_index_reg;
    logic                            res_done_reg;
    logic                            res_err_reg;

    logic                            draw_valid_reg;
    logic [fwis_pkg::WORD_W-1:0]     drawn_index_reg;
    logic                            set_done_reg;
    logic                            config_error_reg;

    fwis_pkg::fwis_mac_ctrl_t        mac_ctrl;
    logic [fwis_pkg::WORD_W-1:0]     cur_range;
    logic [fwis_pkg::WORD_W-1:0]     acc_hi;

    logic                            accept;
    logic                            complete;
    logic                            bad;
    logic                            launch;
    logic                            write_go;
    logic                            emit_go;

    logic [MW:0]                     tok_valid_vec;
    fwis_pkg::fwis_token_t           tok_chain [MW+1];
    fwis_pkg::fwis_token_t           tail;
    logic                            last_draw;

    // register port
    assign pready    = 1'b1;
    assign reg_sel   = paddr[fwis_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            fwis_pkg::REG_RANGE_SIZE: prdata = range_size_reg;
            fwis_pkg::REG_WEIGHT:     prdata = fwis_pkg::WORD_W'(weight_reg);
            fwis_pkg::REG_SECURITY:   prdata = fwis_pkg::WORD_W'(security_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_size_reg <= fwis_pkg::WORD_W'(1);
            weight_reg     <= fwis_pkg::WEIGHT_W'(1);
            security_reg   <= fwis_pkg::SEC_128;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                fwis_pkg::REG_RANGE_SIZE: range_size_reg <= pwdata;
                fwis_pkg::REG_WEIGHT:     weight_reg <= pwdata[fwis_pkg::WEIGHT_W-1:0];
                fwis_pkg::REG_SECURITY:   security_reg <= pwdata[fwis_pkg::LEVEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // reduction
    assign cur_range = range_size_reg - fwis_pkg::WORD_W'(draw_count_reg);

    fwis_lemire u_lemire (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .limb   (limb_reg),
        .range  (cur_range),
        .acc_hi (acc_hi)
    );

    assign complete = limb_count_reg >= fwis_pkg::limbs_per_draw(security_reg);
    assign bad = (weight_reg == '0)
              || (fwis_pkg::WORD_W'(weight_reg) > fwis_pkg::WORD_W'(MW))
              || (fwis_pkg::WORD_W'(weight_reg) > range_size_reg)
              || (security_reg > fwis_pkg::SEC_256)
              || (fwis_pkg::WORD_W'(draw_count_reg) >= fwis_pkg::WORD_W'(weight_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fwis_pkg::ST_IDLE:
            begin
                if (tape_valid)
                begin
                    state_next = fwis_pkg::ST_MUL;
                end
            end
            fwis_pkg::ST_MUL:   state_next = fwis_pkg::ST_ACC;
            fwis_pkg::ST_ACC:   state_next = fwis_pkg::ST_CHECK;
            fwis_pkg::ST_CHECK:
            begin
                if (!complete)
                begin
                    state_next = fwis_pkg::ST_IDLE;
                end
                else if (bad)
                begin
                    state_next = fwis_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = fwis_pkg::ST_SCAN;
                end
            end
            fwis_pkg::ST_SCAN:
            begin
                if (tok_valid_vec[MW])
                begin
                    state_next = fwis_pkg::ST_EMIT;
                end
            end
            fwis_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = fwis_pkg::ST_IDLE;
                end
            end
            default:            state_next = fwis_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        mac_ctrl.mul_en  = (state_reg == fwis_pkg::ST_MUL);
        mac_ctrl.acc_en  = (state_reg == fwis_pkg::ST_ACC);
        mac_ctrl.acc_clr = (state_reg == fwis_pkg::ST_CHECK) && complete;
        accept     = (state_reg == fwis_pkg::ST_IDLE) && tape_valid;
        tape_stall = (state_reg != fwis_pkg::ST_IDLE);
        launch     = (state_reg == fwis_pkg::ST_CHECK) && complete && !bad;
        write_go   = (state_reg == fwis_pkg::ST_SCAN) && tok_valid_vec[MW];
        emit_go    = (state_reg == fwis_pkg::ST_EMIT) && (!draw_valid_reg || !draw_stall);
    end

    // overlay chain, query enters at cell 0 and leaves after the last cell
    assign tok_valid_vec[0]    = launch;
    assign tok_chain[0].remaining = draw_count_reg;
    assign tok_chain[0].idx_i  = draw_count_reg;
    assign tok_chain[0].idx_j  = fwis_pkg::WORD_W'(draw_count_reg) + acc_hi;
    assign tok_chain[0].cur_i  = fwis_pkg::WORD_W'(draw_count_reg);
    assign tok_chain[0].cur_j  = fwis_pkg::WORD_W'(draw_count_reg) + acc_hi;
    assign tail = tok_chain[MW];

    for (genvar k = 0; k < MW; k++)
    begin : g_cell
        logic wr_en;
        assign wr_en = write_go && (tail.idx_i == fwis_pkg::COUNT_W'(k));

        fwis_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_valid_in  (tok_valid_vec[k]),
            .tok_in        (tok_chain[k]),
            .tok_valid_out (tok_valid_vec[k+1]),
            .tok_out       (tok_chain[k+1]),
            .wr_en         (wr_en),
            .wr_slot       (tail.idx_j),
            .wr_value      (tail.cur_i)
        );
    end

    assign last_draw = (fwis_pkg::WORD_W'(tail.idx_i) + fwis_pkg::WORD_W'(1))
                    == fwis_pkg::WORD_W'(weight_reg);

    always_comb
    begin
        limb_count_next = limb_count_reg;
        if (state_reg == fwis_pkg::ST_ACC)
        begin
            limb_count_next = limb_count_reg + fwis_pkg::LIMB_CNT_W'(1);
        end
        else if ((state_reg == fwis_pkg::ST_CHECK) && complete)
        begin
            limb_count_next = '0;
        end
    end

    always_comb
    begin
        draw_count_next = draw_count_reg;
        if (emit_go)
        begin
            if (res_err_reg || res_done_reg)
            begin
                draw_count_next = '0;
            end
            else
            begin
                draw_count_next = draw_count_reg + fwis_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fwis_pkg::ST_IDLE;
            limb_count_reg <= '0;
            draw_count_reg <= '0;
            draw_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limb_count_reg <= limb_count_next;
            draw_count_reg <= draw_count_next;
            if (emit_go)
            begin
                draw_valid_reg <= 1'b1;
            end
            else if (!draw_stall)
            begin
                draw_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            limb_reg <= tape_word;
        end
        if ((state_reg == fwis_pkg::ST_CHECK) && complete && bad)
        begin
            res_index_reg <= '0;
            res_done_reg  <= 1'b1;
            res_err_reg   <= 1'b1;
        end
        else if (write_go)
        begin
            res_index_reg <= tail.cur_j;
            res_done_reg  <= last_draw;
            res_err_reg   <= 1'b0;
        end
        // output beat register
        if (emit_go)
        begin
            drawn_index_reg  <= res_index_reg;
            set_done_reg     <= res_done_reg;
            config_error_reg <= res_err_reg;
        end
    end

    assign draw_valid   = draw_valid_reg;
    assign drawn_index  = drawn_index_reg;
    assign set_done     = set_done_reg;
    assign config_error = config_error_reg;

    a_single_query: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one query in the overlay chain");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_vec[MW] |-> state_reg == fwis_pkg::ST_SCAN)
        else $error("query left the chain outside the scan");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (draw_valid && config_error) |-> (drawn_index == '0) && set_done)
        else $error("error beat carries an index or misses set end");

    a_limb_bound: assert property (@(posedge clk) disable iff (!rst_n)
        limb_count_reg <= fwis_pkg::LIMBS_256)
        else $error("limb count ran past the longest draw");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> draw_valid)
        else $error("emitted result not presented");

endmodule

// ===== rtl/core/fwis_cell.sv =====
// fwis_cell: one overlay entry (displaced slot and its value) plus one token stage
// depends on fwis_pkg
module fwis_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid_in,
    input  fwis_pkg::fwis_token_t tok_in,
    output logic                tok_valid_out,
    output fwis_pkg::fwis_token_t tok_out,
    input  logic                wr_en,
    input  logic [fwis_pkg::WORD_W-1:0] wr_slot,
    input  logic [fwis_pkg::WORD_W-1:0] wr_value
);

    logic [fwis_pkg::WORD_W-1:0] slot_reg;
    logic [fwis_pkg::WORD_W-1:0] value_reg;
    logic                        tok_valid_reg;
    fwis_pkg::fwis_token_t       tok_reg;
    fwis_pkg::fwis_token_t       tok_next;
    logic                        active;

    // entry only counts while the token still has earlier draws to pass
    assign active = tok_valid_in && (tok_in.remaining != '0);

    always_comb
    begin
        tok_next = tok_in;
        if (active)
        begin
            tok_next.remaining = tok_in.remaining - fwis_pkg::COUNT_W'(1);
            if (slot_reg == fwis_pkg::WORD_W'(tok_in.idx_i))
            begin
                tok_next.cur_i = value_reg;
            end
            if (slot_reg == tok_in.idx_j)
            begin
                tok_next.cur_j = value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (wr_en)
        begin
            slot_reg  <= wr_slot;
            value_reg <= wr_value;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ===== rtl/core/fwis_lemire.sv =====
// fwis_lemire: multiply-accumulate for the high-word range reduction
// depends on fwis_pkg
module fwis_lemire (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fwis_pkg::fwis_mac_ctrl_t     ctrl,
    input  logic [fwis_pkg::WORD_W-1:0]  limb,
    input  logic [fwis_pkg::WORD_W-1:0]  range,
    output logic [fwis_pkg::WORD_W-1:0]  acc_hi
);

    logic [fwis_pkg::ACC_W-1:0] prod_reg;
    logic [fwis_pkg::ACC_W-1:0] acc_reg;
    logic [fwis_pkg::ACC_W-1:0] acc_next;

    assign acc_hi = acc_reg[fwis_pkg::ACC_W-1:fwis_pkg::WORD_W];

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = prod_reg + fwis_pkg::ACC_W'(acc_hi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= fwis_pkg::ACC_W'(limb) * fwis_pkg::ACC_W'(range);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== tb/sv/fixed_weight_index_sampler_tb.sv =====
`timescale 1ns / 100ps
// fixed_weight_index_sampler_tb: self-checking bench for the fixed-weight index sampler
// holds its own model of the lemire reduction and the shuffle overlay; depends on fwis_pkg
// and the rtl of fixed_weight_index_sampler
module fixed_weight_index_sampler_tb;

    localparam logic [fwis_pkg::LEVEL_W-1:0] LEVEL_RESERVED = 2'd3;

    // settle time for the slowest draw: every limb of the longest level plus the walk down the cell chain
    localparam int SETTLE_CYCLES  = 4 * 10 + fwis_pkg::MAX_WEIGHT + 32;
    localparam int WATCHDOG_LIMIT = 20 * SETTLE_CYCLES;
    localparam int RANDOM_WORDS   = 750;

    typedef struct packed {
        logic [fwis_pkg::WORD_W-1:0] idx;
        logic                        done;
        logic                        err;
    } drawn_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [fwis_pkg::ADDR_W-1:0]   paddr = '0;
    logic [fwis_pkg::WORD_W-1:0]   pwdata = '0;
    logic [fwis_pkg::WORD_W-1:0]   prdata;
    logic                          pready;
    logic                          tape_valid = 1'b0;
    logic                          tape_stall;
    logic [fwis_pkg::WORD_W-1:0]   tape_word = '0;
    logic                          draw_valid;
    logic                          draw_stall = 1'b0;
    logic [fwis_pkg::WORD_W-1:0]   drawn_index;
    logic                          set_done;
    logic                          config_error;

    // shadow of the block's registers and draw state
    logic [fwis_pkg::WORD_W-1:0]   cfg_range = 32'd1;
    logic [fwis_pkg::WEIGHT_W-1:0] cfg_weight = 8'd1;
    logic [fwis_pkg::LEVEL_W-1:0]  cfg_level = fwis_pkg::SEC_128;
    logic [7:0]                    draw_count = '0;
    logic [3:0]                    limbs_in = '0;
    logic [fwis_pkg::ACC_W-1:0]    lemire_acc = '0;
    logic [fwis_pkg::WORD_W-1:0]   displaced_slot [fwis_pkg::MAX_WEIGHT];
    logic [fwis_pkg::WORD_W-1:0]   displaced_value [fwis_pkg::MAX_WEIGHT];

    logic [fwis_pkg::WORD_W-1:0]   tape_backlog [$];
    drawn_t                        pending_draws [$];
    logic                          tape_taken = 1'b0;
    int                            tape_queued = 0;
    int                            tape_accepts = 0;
    int                            failures = 0;
    int                            quiet_cycles = 0;
    int                            send_idle_pct = 0;
    int                            stall_pct = 0;

    fixed_weight_index_sampler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .tape_valid   (tape_valid),
        .tape_stall   (tape_stall),
        .tape_word    (tape_word),
        .draw_valid   (draw_valid),
        .draw_stall   (draw_stall),
        .drawn_index  (drawn_index),
        .set_done     (set_done),
        .config_error (config_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int limbs_for(input logic [fwis_pkg::LEVEL_W-1:0] lvl);
        return (lvl == fwis_pkg::SEC_128) ? 6 : (lvl == fwis_pkg::SEC_192) ? 8 : 10;
    endfunction

    // fold one tape limb in; a finished draw leaves its result in pending_draws
    function automatic void absorb_limb(input logic [fwis_pkg::WORD_W-1:0] limb);
        logic [fwis_pkg::WORD_W-1:0] slot_i;
        logic [fwis_pkg::WORD_W-1:0] slot_j;
        logic [fwis_pkg::WORD_W-1:0] val_i;
        logic [fwis_pkg::WORD_W-1:0] val_j;
        logic [fwis_pkg::WORD_W-1:0] span;
        drawn_t                      res;
        slot_i = {24'd0, draw_count};
        span = cfg_range - slot_i;
        lemire_acc = {32'd0, limb} * {32'd0, span} + (lemire_acc >> 32);
        limbs_in = limbs_in + 4'd1;
        if (int'(limbs_in) < limbs_for(cfg_level))
            return;
        slot_j = slot_i + lemire_acc[63:32];
        limbs_in = '0;
        lemire_acc = '0;
        if (cfg_weight == 0 || cfg_weight > fwis_pkg::MAX_WEIGHT ||
            {24'd0, cfg_weight} > cfg_range ||
            cfg_level == LEVEL_RESERVED || draw_count >= cfg_weight)
        begin
            draw_count = '0;
            res.idx = '0;
            res.done = 1'b1;
            res.err = 1'b1;
        end
        else
        begin
            val_i = slot_i;
            val_j = slot_j;
            // later overlay entries win
            for (int k = 0; k < int'(draw_count); k++)
            begin
                if (displaced_slot[k] == slot_i)
                    val_i = displaced_value[k];
                if (displaced_slot[k] == slot_j)
                    val_j = displaced_value[k];
            end
            displaced_slot[draw_count[6:0]] = slot_j;
            displaced_value[draw_count[6:0]] = val_i;
            res.idx = val_j;
            res.err = 1'b0;
            res.done = (draw_count + 8'd1 == cfg_weight);
            draw_count = res.done ? 8'd0 : draw_count + 8'd1;
        end
        pending_draws.push_back(res);
    endfunction

    task automatic push_limb(input logic [fwis_pkg::WORD_W-1:0] limb);
        tape_backlog.push_back(limb);
        tape_queued++;
    endtask

    task automatic queue_tape(input int count);
        repeat (count)
            push_limb($urandom);
    endtask

    // everything sent has been taken and every draw seen, then let the block settle
    task automatic wait_drained();
        while (tape_accepts != tape_queued || pending_draws.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write then read back one register
    task automatic program_reg(input logic [fwis_pkg::REG_SEL_W-1:0] sel,
                               input logic [fwis_pkg::WORD_W-1:0] value);
        logic [fwis_pkg::WORD_W-1:0] stored;
        logic [fwis_pkg::WORD_W-1:0] readback;
        case (sel)
            fwis_pkg::REG_RANGE_SIZE:
            begin
                cfg_range = value;
                stored = value;
            end
            fwis_pkg::REG_WEIGHT:
            begin
                cfg_weight = value[fwis_pkg::WEIGHT_W-1:0];
                stored = {24'd0, value[fwis_pkg::WEIGHT_W-1:0]};
            end
            default:
            begin
                cfg_level = value[fwis_pkg::LEVEL_W-1:0];
                stored = {30'd0, value[fwis_pkg::LEVEL_W-1:0]};
            end
        endcase
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== stored)
        begin
            $display("%0t register %0d readback expected %h got %h", $time, sel, stored,
                     readback);
            failures++;
        end
    endtask

    task automatic apply_settings(input logic [fwis_pkg::WORD_W-1:0] n,
                                  input logic [fwis_pkg::WEIGHT_W-1:0] w,
                                  input logic [fwis_pkg::LEVEL_W-1:0] lvl);
        program_reg(fwis_pkg::REG_RANGE_SIZE, n);
        program_reg(fwis_pkg::REG_WEIGHT, {24'd0, w});
        program_reg(fwis_pkg::REG_SECURITY, {30'd0, lvl});
    endtask

    // tape driver: a stalled beat holds, a new one goes out only after acceptance
    always @(negedge clk)
    begin
        if (!tape_valid || tape_taken)
        begin
            tape_taken = 1'b0;
            if (tape_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                tape_valid <= 1'b1;
                tape_word <= tape_backlog.pop_front();
            end
            else
                tape_valid <= 1'b0;
        end
        draw_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        drawn_t want;
        if (tape_valid && !tape_stall)
        begin
            absorb_limb(tape_word);
            tape_taken = 1'b1;
            tape_accepts++;
        end
        if (draw_valid && !draw_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t unexpected draw beat: index %h done %b error %b", $time,
                         drawn_index, set_done, config_error);
                failures++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (drawn_index !== want.idx)
                begin
                    $display("%0t drawn_index expected %h got %h", $time, want.idx,
                             drawn_index);
                    failures++;
                end
                if (set_done !== want.done)
                begin
                    $display("%0t set_done expected %b got %b", $time, want.done, set_done);
                    failures++;
                end
                if (config_error !== want.err)
                begin
                    $display("%0t config_error expected %b got %b", $time, want.err,
                             config_error);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((tape_valid && !tape_stall) || (draw_valid && !draw_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [fwis_pkg::WORD_W-1:0]   n;
        logic [fwis_pkg::WEIGHT_W-1:0] w;
        logic [fwis_pkg::LEVEL_W-1:0]  lvl;
        int                            draws;
        int                            words;
        int                            phase;
        int                            random_words;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, tape limbs at both extremes
        for (int k = 0; k < 6; k++)
            push_limb((k % 2 == 0) ? 32'hFFFF_FFFF : 32'h0);
        wait_drained();

        // widest range, full weight, then stop three limbs into the next draw
        apply_settings(32'hFFFF_FFFF, 8'd128, fwis_pkg::SEC_128);
        repeat (6) push_limb(32'hFFFF_FFFF);
        repeat (3) push_limb(32'h0);
        wait_drained();

        // reserved level and zero weight picked up mid-draw: ten limbs, then an error
        apply_settings(32'hFFFF_FFFF, 8'd0, LEVEL_RESERVED);
        queue_tape(7);
        wait_drained();

        phase = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct = 15;
                end
            endcase
            lvl = fwis_pkg::LEVEL_W'($urandom_range(2));
            if (phase == 2)
            begin
                // deep overlay: long permutation run, left open for the next settings
                n = 32'd128;
                w = 8'd128;
                lvl = fwis_pkg::SEC_128;
                draws = 48;
            end
            else
            begin
                w = fwis_pkg::WEIGHT_W'($urandom_range(1, 6));
                case ($urandom_range(3))
                    0: n = {24'd0, w};
                    1: n = {24'd0, w} + 32'($urandom_range(1, 20));
                    2: n = $urandom | 32'h80;
                    default: n = 32'hFFFF_FFFF;
                endcase
                draws = $urandom_range(1, 2 * w + 1);
                if ($urandom_range(4) == 0)
                begin
                    case ($urandom_range(3))
                        0: w = 8'd0;
                        1: w = fwis_pkg::WEIGHT_W'($urandom_range(129, 255));
                        2:
                        begin
                            n = $urandom_range(1, 5);
                            w = 8'(n) + 8'd1;
                        end
                        default: lvl = LEVEL_RESERVED;
                    endcase
                end
            end
            apply_settings(n, w, lvl);
            words = draws * limbs_for(lvl);
            if ($urandom_range(3) == 0)
                words += $urandom_range(limbs_for(lvl) - 1);
            queue_tape(words);
            random_words += words;
            wait_drained();
            phase++;
        end

        if (failures == 0 && pending_draws.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
